[design/slou_pkg.sv]
// ----------------------------------------------------------------------------
// slou_pkg
// Shared widths, operation codes and constants for the streaming list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package slou_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 6;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned POS_HW_MAX = 2047;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ARG = 1'd1;

  // maps
  localparam logic [OP_W-1:0] OP_MAP_INC   = 6'd0;
  localparam logic [OP_W-1:0] OP_MAP_DEC   = 6'd1;
  localparam logic [OP_W-1:0] OP_MAP_MUL2  = 6'd2;
  localparam logic [OP_W-1:0] OP_MAP_DIV2  = 6'd3;
  localparam logic [OP_W-1:0] OP_MAP_NEG   = 6'd4;
  localparam logic [OP_W-1:0] OP_MAP_SQR   = 6'd5;
  localparam logic [OP_W-1:0] OP_MAP_MUL3  = 6'd6;
  localparam logic [OP_W-1:0] OP_MAP_DIV3  = 6'd7;
  localparam logic [OP_W-1:0] OP_MAP_MUL4  = 6'd8;
  localparam logic [OP_W-1:0] OP_MAP_DIV4  = 6'd9;
  // filters
  localparam logic [OP_W-1:0] OP_FILT_POS  = 6'd10;
  localparam logic [OP_W-1:0] OP_FILT_EVEN = 6'd13;
  // counts
  localparam logic [OP_W-1:0] OP_CNT_POS   = 6'd14;
  localparam logic [OP_W-1:0] OP_CNT_EVEN  = 6'd17;
  // scans
  localparam logic [OP_W-1:0] OP_SCAN_ADD  = 6'd18;
  localparam logic [OP_W-1:0] OP_SCAN_MUL  = 6'd20;
  localparam logic [OP_W-1:0] OP_SCAN_MIN  = 6'd22;
  // reductions
  localparam logic [OP_W-1:0] OP_RED_MAX   = 6'd23;
  localparam logic [OP_W-1:0] OP_RED_MIN   = 6'd24;
  localparam logic [OP_W-1:0] OP_RED_HEAD  = 6'd25;
  localparam logic [OP_W-1:0] OP_RED_LAST  = 6'd26;
  localparam logic [OP_W-1:0] OP_RED_SUM   = 6'd27;
  // zipwith
  localparam logic [OP_W-1:0] OP_ZIP_ADD   = 6'd28;
  localparam logic [OP_W-1:0] OP_ZIP_MUL   = 6'd30;
  localparam logic [OP_W-1:0] OP_ZIP_MIN   = 6'd32;
  // positional
  localparam logic [OP_W-1:0] OP_TAKE      = 6'd33;
  localparam logic [OP_W-1:0] OP_DROP      = 6'd34;
  localparam logic [OP_W-1:0] OP_ACCESS    = 6'd35;

  // binary op selector within scan / zipwith groups
  localparam logic [2:0] BIN_ADD = 3'd0;
  localparam logic [2:0] BIN_SUB = 3'd1;
  localparam logic [2:0] BIN_MUL = 3'd2;
  localparam logic [2:0] BIN_MAX = 3'd3;

  // predicate selector within filter / count groups
  localparam logic [1:0] PRED_POS = 2'd0;
  localparam logic [1:0] PRED_NEG = 2'd1;
  localparam logic [1:0] PRED_ODD = 2'd2;

  localparam logic [DATA_W-1:0] INT_MIN_VAL   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX_VAL   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] BAD_INDEX_VAL = 32'hFFF0_BDC0; // -1000000
  // ceil(2^33 / 3): exact quotient for any 32-bit magnitude after >> 33
  localparam logic [DATA_W-1:0] DIV3_RECIP    = 32'hAAAA_AAAB;

endpackage

`default_nettype wire

[design/slou_if.sv]
// ----------------------------------------------------------------------------
// slou_if
// Valid/ready channel interfaces: list input, result output, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface slou_in_if import slou_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] a_value;
  logic signed [DATA_W-1:0] b_value;
  logic                     element_valid;
  logic                     last;

  modport source (output valid, a_value, b_value, element_valid, last, input ready);
  modport sink   (input valid, a_value, b_value, element_valid, last, output ready);
endinterface

interface slou_out_if import slou_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     value_valid;
  logic                     end_of_list;

  modport source (output valid, result_value, value_valid, end_of_list, input ready);
  modport sink   (input valid, result_value, value_valid, end_of_list, output ready);
endinterface

interface slou_cfg_if import slou_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/streaming_list_op_unit.sv]
// ----------------------------------------------------------------------------
// streaming_list_op_unit
// Map / filter / count / scan / reduce / zipwith / take / drop / access over a
// streamed list, one element (or element pair) per beat.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                      beat when
//   in_i     in   a_value, b_value, element_valid, last        valid & ready
//   out_o    out  result_value, value_valid, end_of_list       valid & ready
//   cfg_i    in   index (0 operation, 1 count_argument), data  valid & ready
//
// One beat per cycle sustained while out_o is ready. The input register feeds
// the compute stage, which writes list state and the result register. The
// scan-multiply recurrence through the shared 32x32 multiplier sets the stage
// length. Reset clears config and list state; no clearing pass. A stalled result
// register holds back the input stage only; cfg_i is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_list_op_unit import slou_pkg::*; #(
  parameter int unsigned MAX_LIST_LENGTH = 1024
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  slou_in_if.sink    in_i,
  slou_out_if.source out_o,
  slou_cfg_if.sink   cfg_i
);

  localparam int unsigned POS_CAP = (MAX_LIST_LENGTH < POS_HW_MAX) ? MAX_LIST_LENGTH
                                                                   : POS_HW_MAX;
  localparam logic [POS_W-1:0] POS_CAP_C = POS_W'(POS_CAP);

  // config
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] carg_q;

  // input register
  logic              s1_v_q;
  logic [DATA_W-1:0] s1_a_q, s1_b_q;
  logic              s1_ev_q, s1_last_q;

  // list state
  logic [POS_W-1:0]  pos_q, pos_n;
  logic [DATA_W-1:0] run_q, run_n;
  logic              hf_q, hf_n;
  logic [POS_W-1:0]  tally_q, tally_n;
  logic [DATA_W-1:0] pick_q, pick_n;
  logic              found_q, found_n;

  // result register
  logic              out_v_q;
  logic [DATA_W-1:0] out_rv_q;
  logic              out_vv_q, out_eol_q;

  logic              fire, has_result;
  logic              emit;
  logic [DATA_W-1:0] val;

  logic [DATA_W-1:0]   mul_x, mul_y;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   mag;
  logic [DATA_W-1:0]   div3_q;
  logic [DATA_W-1:0]   bias2, bias4;
  logic [DATA_W-1:0]   pos_ext;

  function automatic logic [DATA_W-1:0] smax(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
    return ($signed(x) > $signed(y)) ? x : y;
  endfunction

  function automatic logic [DATA_W-1:0] smin(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
    return ($signed(x) < $signed(y)) ? x : y;
  endfunction

  function automatic logic pred(logic [1:0] k, logic [DATA_W-1:0] x);
    logic r;
    case (k)
      PRED_POS: r = ($signed(x) > 0);
      PRED_NEG: r = x[DATA_W-1];
      PRED_ODD: r = x[0];
      default:  r = ~x[0];
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] bin_op(logic [2:0] k, logic [DATA_W-1:0] x,
                                               logic [DATA_W-1:0] y, logic [DATA_W-1:0] p);
    logic [DATA_W-1:0] r;
    case (k)
      BIN_ADD: r = x + y;
      BIN_SUB: r = x - y;
      BIN_MUL: r = p;
      BIN_MAX: r = smax(x, y);
      default: r = smin(x, y);
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign fire        = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready  = !s1_v_q || fire;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= '0;
      carg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_OPERATION: op_q   <= cfg_i.data[OP_W-1:0];
        REG_COUNT_ARG: carg_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_a_q    <= in_i.a_value;
      s1_b_q    <= in_i.b_value;
      s1_ev_q   <= in_i.element_valid;
      s1_last_q <= in_i.last;
    end
  end

  // --------------------------------------------------------------------------
  // shared multiplier: square, divide-by-3 reciprocal, scan and zip multiply
  // --------------------------------------------------------------------------
  assign mag = s1_a_q[DATA_W-1] ? (~s1_a_q + 1'b1) : s1_a_q;

  always_comb begin
    mul_x = s1_a_q;
    mul_y = s1_b_q;
    if (op_q == OP_MAP_SQR) begin
      mul_y = s1_a_q;
    end else if (op_q == OP_MAP_DIV3) begin
      mul_x = mag;
      mul_y = DIV3_RECIP;
    end else if (op_q == OP_SCAN_MUL) begin
      mul_x = run_q;
      mul_y = s1_a_q;
    end
  end

  assign prod   = mul_x * mul_y;
  assign div3_q = DATA_W'(prod[2*DATA_W-1:DATA_W+1]);
  assign bias2  = s1_a_q + (s1_a_q[DATA_W-1] ? 32'd1 : 32'd0);
  assign bias4  = s1_a_q + (s1_a_q[DATA_W-1] ? 32'd3 : 32'd0);
  assign pos_ext = {{(DATA_W-POS_W){1'b0}}, pos_q};

  // --------------------------------------------------------------------------
  // compute stage
  // --------------------------------------------------------------------------
  always_comb begin
    emit    = 1'b0;
    val     = '0;
    pos_n   = pos_q;
    run_n   = run_q;
    hf_n    = hf_q;
    tally_n = tally_q;
    pick_n  = pick_q;
    found_n = found_q;

    if (s1_ev_q) begin
      if (op_q <= OP_MAP_DIV4) begin
        emit = 1'b1;
        case (op_q)
          OP_MAP_INC:  val = s1_a_q + 1'b1;
          OP_MAP_DEC:  val = s1_a_q - 1'b1;
          OP_MAP_MUL2: val = {s1_a_q[DATA_W-2:0], 1'b0};
          OP_MAP_DIV2: val = DATA_W'($signed(bias2) >>> 1);
          OP_MAP_NEG:  val = ~s1_a_q + 1'b1;
          OP_MAP_SQR:  val = prod[DATA_W-1:0];
          OP_MAP_MUL3: val = s1_a_q + {s1_a_q[DATA_W-2:0], 1'b0};
          OP_MAP_DIV3: val = s1_a_q[DATA_W-1] ? (~div3_q + 1'b1) : div3_q;
          OP_MAP_MUL4: val = {s1_a_q[DATA_W-3:0], 2'b00};
          default:     val = DATA_W'($signed(bias4) >>> 2);
        endcase
      end else if (op_q <= OP_FILT_EVEN) begin
        if (pred(2'(op_q - OP_FILT_POS), s1_a_q)) begin
          emit = 1'b1;
          val  = s1_a_q;
        end
      end else if (op_q <= OP_CNT_EVEN) begin
        if (pred(2'(op_q - OP_CNT_POS), s1_a_q) && (tally_q < POS_CAP_C)) begin
          tally_n = tally_q + 1'b1;
        end
      end else if (op_q <= OP_SCAN_MIN) begin
        run_n = hf_q ? bin_op(3'(op_q - OP_SCAN_ADD), run_q, s1_a_q, prod[DATA_W-1:0])
                     : s1_a_q;
        emit  = 1'b1;
        val   = run_n;
      end else if (op_q <= OP_RED_SUM) begin
        if (!hf_q) begin
          run_n = s1_a_q;
        end else begin
          case (op_q)
            OP_RED_MAX:  run_n = smax(run_q, s1_a_q);
            OP_RED_MIN:  run_n = smin(run_q, s1_a_q);
            OP_RED_LAST: run_n = s1_a_q;
            OP_RED_SUM:  run_n = run_q + s1_a_q;
            default:     run_n = run_q; // head keeps the first element
          endcase
        end
      end else if (op_q <= OP_ZIP_MIN) begin
        emit = 1'b1;
        val  = bin_op(3'(op_q - OP_ZIP_ADD), s1_a_q, s1_b_q, prod[DATA_W-1:0]);
      end else if (op_q == OP_TAKE) begin
        if ($signed(pos_ext) < $signed(carg_q)) begin
          emit = 1'b1;
          val  = s1_a_q;
        end
      end else if (op_q == OP_DROP) begin
        if (!carg_q[DATA_W-1] && (pos_ext >= carg_q)) begin
          emit = 1'b1;
          val  = s1_a_q;
        end
      end else if (op_q == OP_ACCESS) begin
        if (!found_q && (pos_ext == carg_q)) begin
          found_n = 1'b1;
          pick_n  = s1_a_q;
        end
      end
      hf_n = 1'b1;
      if (pos_q < POS_CAP_C) begin
        pos_n = pos_q + 1'b1;
      end
    end

    if (s1_last_q) begin
      if (op_q >= OP_CNT_POS && op_q <= OP_CNT_EVEN) begin
        emit = 1'b1;
        val  = {{(DATA_W-POS_W){1'b0}}, tally_n};
      end else if (op_q >= OP_RED_MAX && op_q <= OP_RED_SUM) begin
        emit = 1'b1;
        if (hf_n)                    val = run_n;
        else if (op_q == OP_RED_MAX) val = INT_MIN_VAL;
        else if (op_q == OP_RED_MIN) val = INT_MAX_VAL;
        else                         val = '0;
      end else if (op_q == OP_ACCESS) begin
        emit = 1'b1;
        val  = found_n ? pick_n : BAD_INDEX_VAL;
      end
      if (!emit) begin
        val = '0;
      end
      pos_n   = '0;
      run_n   = '0;
      hf_n    = 1'b0;
      tally_n = '0;
      pick_n  = '0;
      found_n = 1'b0;
    end
  end

  assign has_result = emit || s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      run_q   <= '0;
      hf_q    <= 1'b0;
      tally_q <= '0;
      pick_q  <= '0;
      found_q <= 1'b0;
    end else if (fire) begin
      pos_q   <= pos_n;
      run_q   <= run_n;
      hf_q    <= hf_n;
      tally_q <= tally_n;
      pick_q  <= pick_n;
      found_q <= found_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire && has_result) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      out_rv_q  <= val;
      out_vv_q  <= emit;
      out_eol_q <= s1_last_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.result_value = out_rv_q;
  assign out_o.value_valid  = out_vv_q;
  assign out_o.end_of_list  = out_eol_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_list_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_last_q) |=> (pos_q == '0 && !hf_q && tally_q == '0 && !found_q))
    else $error("list state not cleared after final beat");

  a_pos_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= POS_CAP_C) && (tally_q <= pos_q))
    else $error("position or tally past its bound");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_vv_q) |-> (out_rv_q == '0 && out_eol_q))
    else $error("empty result must be zero and end of list");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |-> !fire)
    else $error("stage fired into a stalled result register");

endmodule

`default_nettype wire

[tb/streaming_list_op_unit_checker.sv]
// ----------------------------------------------------------------------------
// streaming_list_op_unit_checker
// Watches the list, result and register channels of the list unit, keeps its
// own copy of the list state and settings, predicts every result beat and
// compares each one field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module streaming_list_op_unit_checker import slou_pkg::*; #(
  parameter int unsigned MAX_LIST_LENGTH = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  slou_in_if   list_mon,
  slou_out_if  res_mon,
  slou_cfg_if  reg_mon,
  output int   mismatch_count_o,
  output int   outstanding_o,
  output int   results_checked_o,
  output int   lists_done_o,
  output int   elements_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_LIMIT = (MAX_LIST_LENGTH < POS_HW_MAX) ? MAX_LIST_LENGTH : POS_HW_MAX;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              value_valid;
    logic              end_of_list;
  } list_result_t;

  // settings and per-list state
  logic [OP_W-1:0]          cur_op;
  logic signed [DATA_W-1:0] cur_arg;
  logic [POS_W-1:0]         pos;
  logic [DATA_W-1:0]        run_val;
  logic                     seen_any;
  logic [POS_W-1:0]         tally;
  logic [DATA_W-1:0]        pick_val;
  logic                     pick_hit;

  list_result_t result_q[$];

  function automatic logic [DATA_W-1:0] map_apply(input logic [OP_W-1:0] k,
                                                  input logic [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] sx;
    sx = x;
    case (k)
      OP_MAP_INC:  return x + 32'd1;
      OP_MAP_DEC:  return x - 32'd1;
      OP_MAP_MUL2: return x * 32'd2;
      OP_MAP_DIV2: return sx / 32'sd2;
      OP_MAP_NEG:  return 32'd0 - x;
      OP_MAP_SQR:  return x * x;
      OP_MAP_MUL3: return x * 32'd3;
      OP_MAP_DIV3: return sx / 32'sd3;
      OP_MAP_MUL4: return x * 32'd4;
      default:     return sx / 32'sd4;
    endcase
  endfunction

  function automatic bit pred_hit(input logic [1:0] k, input logic [DATA_W-1:0] x);
    case (k)
      PRED_POS: return $signed(x) > 0;
      PRED_NEG: return $signed(x) < 0;
      PRED_ODD: return x[0];
      default:  return !x[0];
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] bin_apply(input logic [2:0] k,
                                                  input logic [DATA_W-1:0] x,
                                                  input logic [DATA_W-1:0] y);
    case (k)
      BIN_ADD: return x + y;
      BIN_SUB: return x - y;
      BIN_MUL: return x * y;
      BIN_MAX: return ($signed(x) > $signed(y)) ? x : y;
      default: return ($signed(x) < $signed(y)) ? x : y;
    endcase
  endfunction

  function automatic void clear_list_state();
    pos      = '0;
    run_val  = '0;
    seen_any = 1'b0;
    tally    = '0;
    pick_val = '0;
    pick_hit = 1'b0;
  endfunction

  task automatic list_step(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                           input logic has_elem, input logic is_last,
                           output bit emit, output list_result_t r);
    logic [DATA_W-1:0] v;
    int p;
    emit = 1'b0;
    v = '0;
    r = '0;
    if (has_elem) begin
      p = int'(pos);
      if (cur_op <= OP_MAP_DIV4) begin
        emit = 1'b1;
        v = map_apply(cur_op, a);
      end else if (cur_op <= OP_FILT_EVEN) begin
        if (pred_hit(2'(cur_op - OP_FILT_POS), a)) begin
          emit = 1'b1;
          v = a;
        end
      end else if (cur_op <= OP_CNT_EVEN) begin
        if (pred_hit(2'(cur_op - OP_CNT_POS), a) && tally < POS_LIMIT)
          tally = tally + 1'b1;
      end else if (cur_op <= OP_SCAN_MIN) begin
        run_val = seen_any ? bin_apply(3'(cur_op - OP_SCAN_ADD), run_val, a) : a;
        emit = 1'b1;
        v = run_val;
      end else if (cur_op <= OP_RED_SUM) begin
        if (!seen_any) begin
          run_val = a;
        end else begin
          case (cur_op)
            OP_RED_MAX:  run_val = ($signed(a) > $signed(run_val)) ? a : run_val;
            OP_RED_MIN:  run_val = ($signed(a) < $signed(run_val)) ? a : run_val;
            OP_RED_LAST: run_val = a;
            OP_RED_SUM:  run_val = run_val + a;
            default: ;
          endcase
        end
      end else if (cur_op <= OP_ZIP_MIN) begin
        emit = 1'b1;
        v = bin_apply(3'(cur_op - OP_ZIP_ADD), a, b);
      end else if (cur_op == OP_TAKE) begin
        if (p < cur_arg) begin
          emit = 1'b1;
          v = a;
        end
      end else if (cur_op == OP_DROP) begin
        if (cur_arg >= 0 && p >= cur_arg) begin
          emit = 1'b1;
          v = a;
        end
      end else if (cur_op == OP_ACCESS) begin
        if (!pick_hit && p == cur_arg) begin
          pick_hit = 1'b1;
          pick_val = a;
        end
      end
      seen_any = 1'b1;
      if (pos < POS_LIMIT)
        pos = pos + 1'b1;
    end

    if (is_last) begin
      if (cur_op >= OP_CNT_POS && cur_op <= OP_CNT_EVEN) begin
        emit = 1'b1;
        v = {{(DATA_W-POS_W){1'b0}}, tally};
      end else if (cur_op >= OP_RED_MAX && cur_op <= OP_RED_SUM) begin
        emit = 1'b1;
        if (seen_any)
          v = run_val;
        else if (cur_op == OP_RED_MAX)
          v = INT_MIN_VAL;
        else if (cur_op == OP_RED_MIN)
          v = INT_MAX_VAL;
        else
          v = '0;
      end else if (cur_op == OP_ACCESS) begin
        emit = 1'b1;
        v = pick_hit ? pick_val : BAD_INDEX_VAL;
      end
      r.result_value = emit ? v : '0;
      r.value_valid  = emit;
      r.end_of_list  = 1'b1;
      emit = 1'b1;
      clear_list_state();
    end else if (emit) begin
      r.result_value = v;
      r.value_valid  = 1'b1;
      r.end_of_list  = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatch_count_o < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  task automatic check_result();
    list_result_t want;
    if (result_q.size() == 0) begin
      report_mismatch("result beat with none pending", res_mon.result_value, '0);
    end else begin
      want = result_q.pop_front();
      if (res_mon.result_value !== want.result_value)
        report_mismatch("result_value", res_mon.result_value, want.result_value);
      if (res_mon.value_valid !== want.value_valid)
        report_mismatch("value_valid", res_mon.value_valid, want.value_valid);
      if (res_mon.end_of_list !== want.end_of_list)
        report_mismatch("end_of_list", res_mon.end_of_list, want.end_of_list);
      results_checked_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit           emit;
    list_result_t r;
    if (!rst_ni) begin
      cur_op = OP_MAP_INC;
      cur_arg = '0;
      clear_list_state();
      result_q.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
      results_checked_o = 0;
      lists_done_o = 0;
      elements_seen_o = 0;
    end else begin
      // check first, so a beat can never match a prediction made this edge
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1)
        check_result();
      if (reg_mon.valid === 1'b1 && reg_mon.ready === 1'b1) begin
        if (reg_mon.index == REG_OPERATION)
          cur_op = reg_mon.data[OP_W-1:0];
        else
          cur_arg = reg_mon.data;
      end
      if (list_mon.valid === 1'b1 && list_mon.ready === 1'b1) begin
        list_step(list_mon.a_value, list_mon.b_value, list_mon.element_valid,
                  list_mon.last, emit, r);
        if (emit)
          result_q.insert(result_q.size(), r);
        if (list_mon.element_valid)
          elements_seen_o++;
        if (list_mon.last)
          lists_done_o++;
      end
      outstanding_o = result_q.size();
    end
  end

endmodule

[tb/streaming_list_op_unit_tb.sv]
// ----------------------------------------------------------------------------
// streaming_list_op_unit_tb
// Drives lists through the streaming list unit: a directed pass over the
// corner cases, a sustained back-pressure stretch, then random lists over
// every operation code with random idle bursts on both channels. Results are
// checked by the checker instance; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module streaming_list_op_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slou_pkg::*;

  localparam int unsigned LIST_CAP = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_TAIL   = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_ACCESS + 6'd1;
  localparam logic [OP_W-1:0] OP_UNUSED_TOP   = 6'd63;

  logic clk_i;
  logic rst_ni;

  slou_in_if  list_ch();
  slou_out_if res_ch();
  slou_cfg_if reg_ch();

  int mismatch_count;
  int outstanding;
  int results_checked;
  int lists_done;
  int elements_seen;

  // quiet and hold_req are shared with the result-side ready generator
  logic quiet;
  logic hold_req;
  int unsigned send_gap_pct;
  int items_sent;

  streaming_list_op_unit #(.MAX_LIST_LENGTH(LIST_CAP)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (list_ch),
    .out_o  (res_ch),
    .cfg_i  (reg_ch)
  );

  streaming_list_op_unit_checker #(.MAX_LIST_LENGTH(LIST_CAP)) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .list_mon          (list_ch),
    .res_mon           (res_ch),
    .reg_mon           (reg_ch),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding),
    .results_checked_o (results_checked),
    .lists_done_o      (lists_done),
    .elements_seen_o   (elements_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // result-side ready: windows of no, light or heavy stalling, plus the long hold
  initial begin : result_sink
    int unsigned window;
    int unsigned stall_pct;
    window = 0;
    stall_pct = 0;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (window == 0) begin
        window = $urandom_range(30, 150);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 8;
          default: stall_pct = 35;
        endcase
      end
      window--;
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return INT_MIN_VAL;
      1:       return INT_MAX_VAL;
      2, 3, 4: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_count_arg();
    case ($urandom_range(0, 9))
      0:       return INT_MIN_VAL;
      1:       return INT_MAX_VAL;
      2:       return $urandom();
      3:       return $urandom_range(LIST_CAP - 4, LIST_CAP + 4);
      default: return $urandom_range(0, 14) - 2;
    endcase
  endfunction

  // one beat on the list channel; valid stays high afterwards
  task automatic send_item(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                           input logic has_elem, input logic is_last);
    if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
      list_ch.valid   <= 1'b0;
      list_ch.a_value <= $urandom();
      list_ch.b_value <= $urandom();
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    list_ch.valid         <= 1'b1;
    list_ch.a_value       <= a;
    list_ch.b_value       <= b;
    list_ch.element_valid <= has_elem;
    list_ch.last          <= is_last;
    do @(posedge clk_i); while (list_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic send_list(input int n, input bit empty_end);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(pick_word(), pick_word(), 1'b0, 1'b0);
      send_item(pick_word(), pick_word(), 1'b1, !empty_end && k == n - 1);
      items_sent++;
    end
    if (empty_end || n == 0) begin
      send_item(pick_word(), pick_word(), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  // drain every pending result, then let any result-less beat clear the pipe
  task automatic settle();
    list_ch.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_beat(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk_i); while (reg_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] arg);
    settle();
    // upper bits of the operation word are don't-care
    write_beat(REG_OPERATION, {($urandom_range(0, 1) ? 26'($urandom()) : 26'd0), op});
    write_beat(REG_COUNT_ARG, arg);
    reg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int sweep_op;
    int len;
    logic [OP_W-1:0] op;
    rst_ni = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    send_gap_pct = 0;
    items_sent = 0;
    list_ch.valid = 1'b0;
    list_ch.a_value = '0;
    list_ch.b_value = '0;
    list_ch.element_valid = 1'b0;
    list_ch.last = 1'b0;
    reg_ch.valid = 1'b0;
    reg_ch.index = REG_OPERATION;
    reg_ch.data = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty lists under every reduction default
    configure(OP_RED_MAX, '0);
    send_item('0, '0, 1'b0, 1'b1);
    configure(OP_RED_MIN, INT_MIN_VAL);
    send_item('0, '0, 1'b0, 1'b1);
    configure(OP_RED_HEAD, INT_MAX_VAL);
    send_item(32'd7, '0, 1'b0, 1'b1);
    configure(OP_RED_SUM, '0);
    send_item('0, '0, 1'b0, 1'b1);
    // scan emits the first element as is
    configure(OP_SCAN_MUL, '0);
    send_item(INT_MIN_VAL, INT_MAX_VAL, 1'b1, 1'b0);
    send_item(INT_MAX_VAL, '0, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, '0, 1'b1, 1'b1);
    // division truncation and wrap at the extremes
    configure(OP_MAP_DIV3, '0);
    send_item(INT_MIN_VAL, '0, 1'b1, 1'b0);
    send_item(INT_MAX_VAL, '0, 1'b1, 1'b0);
    send_item(-32'sd7, '0, 1'b1, 1'b1);
    configure(OP_MAP_SQR, '0);
    send_item(INT_MAX_VAL, '0, 1'b1, 1'b0);
    send_item(INT_MIN_VAL, '0, 1'b1, 1'b1);
    // negative take and drop counts emit nothing
    configure(OP_TAKE, INT_MIN_VAL);
    send_item(32'd1, '0, 1'b1, 1'b0);
    send_item(32'd2, '0, 1'b1, 1'b1);
    configure(OP_DROP, 32'hFFFF_FFFF);
    send_item(32'd3, '0, 1'b1, 1'b0);
    send_item(32'd4, '0, 1'b1, 1'b1);
    // access past the end and before the start, with an ignored beat inside
    configure(OP_ACCESS, INT_MAX_VAL);
    send_item(32'd5, '0, 1'b1, 1'b0);
    send_item(32'd99, '0, 1'b0, 1'b0);
    send_item(32'd6, '0, 1'b1, 1'b1);
    configure(OP_ACCESS, 32'hFFFF_FFFF);
    send_item(32'd9, '0, 1'b1, 1'b1);
    // final beat filtered out still closes the list
    configure(OP_FILT_POS, '0);
    send_item(-32'sd5, '0, 1'b1, 1'b1);
    // unused code ignores elements
    configure(OP_UNUSED_TOP, '0);
    send_item(32'd1, '0, 1'b1, 1'b0);
    send_item(32'd2, '0, 1'b0, 1'b1);
    // operation switched mid-list keeps the accumulator
    configure(OP_SCAN_ADD, '0);
    send_item(32'd10, '0, 1'b1, 1'b0);
    send_item(32'd20, '0, 1'b1, 1'b0);
    settle();
    write_beat(REG_OPERATION, {26'd0, OP_RED_SUM});
    reg_ch.valid <= 1'b0;
    send_item(32'd5, '0, 1'b1, 1'b1);

    // long result-side hold while the sender keeps offering beats
    configure(OP_MAP_NEG, '0);
    hold_req = 1'b1;
    send_list(24, 1'b0);

    sweep_op = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = (items_sent + QUIET_TAIL >= RANDOM_ITEMS);
      case ($urandom_range(0, 3))
        0, 1:    send_gap_pct = 0;
        2:       send_gap_pct = 10;
        default: send_gap_pct = 40;
      endcase
      // visit every code up to the first unused one once, then pick at random
      if (sweep_op <= OP_UNUSED_FIRST) begin
        configure(OP_W'(sweep_op), pick_count_arg());
        sweep_op++;
      end else if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 19) == 0)
          op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_TOP));
        else
          op = OP_W'($urandom_range(OP_MAP_INC, OP_ACCESS));
        configure(op, pick_count_arg());
      end
      if ($urandom_range(0, 19) == 0)
        len = $urandom_range(LIST_CAP - 4, LIST_CAP + 16);
      else
        len = $urandom_range(0, 10);
      send_list(len, $urandom_range(0, 3) == 0);
    end

    settle();
    $display("Covered %0d lists, %0d element beats and %0d checked results,",
             lists_done, elements_seen, results_checked);
    $display("over all operation codes, unused codes and lists past the %0d-entry cap.",
             LIST_CAP);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
design/slou_pkg.sv
design/slou_if.sv
design/streaming_list_op_unit.sv
tb/streaming_list_op_unit_checker.sv
tb/streaming_list_op_unit_tb.sv
